FILE: rtl/mecanum_joystick_drive_mixer_unit_macros.svh
// Assertion macros shared by the mixer RTL.
// Depends on nothing; files that check their logic include it.
`ifndef MECANUM_JOYSTICK_DRIVE_MIXER_UNIT_MACROS_SVH
`define MECANUM_JOYSTICK_DRIVE_MIXER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MJDM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MJDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MJDM_ASSERT_IMPL(lbl, ante, cons, msg)
`define MJDM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/mjdm_pkg.sv
// Shared types, constants and datapath step functions of the drive mixer.
// Depends on nothing.
package mjdm_pkg;

  localparam int AdcBits = 10;
  localparam int NumStages = 18;

  localparam logic [1:0] RegTop   = 2'd0;
  localparam logic [1:0] RegFloor = 2'd1;
  localparam logic [1:0] RegDead  = 2'd2;

  localparam logic [7:0] TopReset   = 8'd150;
  localparam logic [7:0] FloorReset = 8'd50;
  localparam logic [7:0] DeadReset  = 8'd10;

  typedef struct packed {
    logic [7:0]  top;
    logic [7:0]  floor_spd;
    logic [7:0]  dead;
    logic [16:0] top_sq;   // (top + 1)^2: first radius square above top
  } cfg_t;

  typedef struct packed {
    logic signed [9:0] ax;
    logic signed [9:0] ay;
    logic [15:0] xx;
    logic [15:0] yy;
    logic [16:0] r2;
    logic [15:0] dmag;
    logic        neg_unit;
    logic        unit_b;
    logic        neg_frac;
    logic        clamp;
    logic        zero;
    logic        neg_slope;
    logic [24:0] rem;
    logic [7:0]  root;
    logic [7:0]  quo;
    logic [7:0]  sp;
  } stage_t;

  typedef struct packed {
    logic       fl_rev;
    logic [7:0] fl_duty;
    logic       fr_rev;
    logic [7:0] fr_duty;
    logic       bl_rev;
    logic [7:0] bl_duty;
    logic       br_rev;
    logic [7:0] br_duty;
  } wheel_t;

  typedef struct packed {
    logic [9:0] rem;
    logic [7:0] root;
  } sq_t;

  typedef struct packed {
    logic [24:0] rem;
    logic [7:0]  quo;
  } dv_t;

  // One digit of a restoring square root: two radicand bits in, one root bit out.
  function automatic sq_t sqrt_step(logic [9:0] rem, logic [7:0] root, logic [1:0] bits);
    logic [11:0] sh;
    logic [11:0] tr;
    logic [11:0] df;
    sq_t         res;
    sh = {rem, bits};
    tr = {2'b00, root, 2'b01};
    df = sh - tr;
    if (sh >= tr) begin
      res.rem  = df[9:0];
      res.root = {root[6:0], 1'b1};
    end else begin
      res.rem  = sh[9:0];
      res.root = {root[6:0], 1'b0};
    end
    return res;
  endfunction

  // One bit of a restoring division against a pre-shifted divisor.
  function automatic dv_t div_step(logic [24:0] rem, logic [7:0] quo, logic [24:0] dsh);
    dv_t res;
    if (rem >= dsh) begin
      res.rem = rem - dsh;
      res.quo = {quo[6:0], 1'b1};
    end else begin
      res.rem = rem;
      res.quo = {quo[6:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic [7:0] duty_of(logic [7:0] mag, logic [7:0] floor_spd);
    return (mag < floor_spd) ? 8'd0 : mag;
  endfunction

endpackage

FILE: rtl/mecanum_joystick_drive_mixer_unit.sv
// Top level of the mecanum drive mixer: stick sample in, four wheel commands out.
// Depends on mjdm_pkg, mjdm_cfg and the assertion macro header.
//
// Use: push one stick sample per item on the in_ channel (stick_x in
// in_tdata[9:0], stick_y in in_tdata[19:10]); each item yields exactly one
// item on the out_ channel with direction and duty for the four wheels.
// One item is taken every cycle while out_tready does not hold the pipeline.
// The pipeline depth is set by the 8-digit square root and the two
// 8-bit restoring dividers (by top_speed, then by the radius square), each
// spread at two digits per pipeline stage.
// Reset clears all valid bits, so no item is in flight afterwards, and
// loads the registers with top 150, floor 50, dead zone 10.
// When the receiver holds out_tready low with a result waiting, the whole
// pipeline holds and in_tready drops; nothing is lost or repeated.
// Write the registers over the cfg_ port only while no item is in flight.
`include "mecanum_joystick_drive_mixer_unit_macros.svh"
module mecanum_joystick_drive_mixer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // stick_x[9:0], stick_y[19:10], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  // fl_reverse[0], fl_duty[8:1], fr_reverse[9], fr_duty[17:10], bl_reverse[18],
  // bl_duty[26:19], br_reverse[27], br_duty[35:28], zero pad
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mjdm_pkg::*;

  cfg_t   cfg;
  stage_t st_r   [NumStages];
  stage_t st_nxt [NumStages];
  wheel_t out_r;
  wheel_t out_nxt;
  logic [NumStages:0] vld_r;
  logic   en;

  mjdm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign en         = !vld_r[NumStages] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NumStages];
  assign out_tdata  = {4'd0, out_r.br_duty, out_r.br_rev, out_r.bl_duty, out_r.bl_rev,
                       out_r.fr_duty, out_r.fr_rev, out_r.fl_duty, out_r.fl_rev};

  logic [AdcBits-1:0]  raw_x;
  logic [AdcBits-1:0]  raw_y;
  logic [AdcBits+8:0]  prod_x;
  logic [AdcBits+8:0]  prod_y;
  logic [7:0]          abs_x;
  logic [7:0]          abs_y;
  logic [9:0]          ax_neg;
  logic [9:0]          ay_neg;
  logic [16:0]         sq_sum;
  logic                dneg;
  logic                q1, q2, q4;
  logic [7:0]          speed;
  logic [7:0]          slope;
  logic [8:0]          slope_w;
  logic [15:0]         pm;
  logic [8:0]          remap;
  logic [23:0]         fm;
  logic [7:0]          frac;
  logic [7:0]          a_mag, b_mag;
  logic                a_neg, b_neg;
  sq_t                 sq_a, sq_b;
  dv_t                 dv_a, dv_b;

  always_comb begin
    raw_x  = in_tdata[AdcBits-1:0];
    raw_y  = in_tdata[AdcBits+9:10];
    prod_x = raw_x * {cfg.top, 1'b0};
    prod_y = raw_y * {cfg.top, 1'b0};
    for (int k = 0; k < NumStages; k++) begin
      st_nxt[k] = (k == 0) ? st_r[0] : st_r[k-1];
    end

    // axis map: y from stick_x, x from stick_y, both negated
    st_nxt[0].ay = $signed({2'b00, cfg.top}) - $signed({1'b0, prod_x[AdcBits+8:AdcBits]});
    st_nxt[0].ax = $signed({2'b00, cfg.top}) - $signed({1'b0, prod_y[AdcBits+8:AdcBits]});

    ax_neg = -st_r[0].ax;
    ay_neg = -st_r[0].ay;
    abs_x  = st_r[0].ax[9] ? ax_neg[7:0] : st_r[0].ax[7:0];
    abs_y  = st_r[0].ay[9] ? ay_neg[7:0] : st_r[0].ay[7:0];
    st_nxt[1].xx = abs_x * abs_x;
    st_nxt[1].yy = abs_y * abs_y;

    // radius square, difference and quadrant
    sq_sum = {1'b0, st_r[1].xx} + {1'b0, st_r[1].yy};
    dneg   = st_r[1].yy < st_r[1].xx;
    q1 = (st_r[1].ax > 0 && st_r[1].ay >= 0) || (st_r[1].ax == 0 && st_r[1].ay == 0);
    q2 = !q1 && st_r[1].ax <= 0 && st_r[1].ay > 0;
    q4 = !q1 && !q2 && !(st_r[1].ax >= 0 && st_r[1].ay < 0);
    st_nxt[2].r2       = sq_sum;
    st_nxt[2].dmag     = dneg ? (st_r[1].xx - st_r[1].yy) : (st_r[1].yy - st_r[1].xx);
    st_nxt[2].neg_unit = q1 || q2;
    st_nxt[2].unit_b   = q1 || q4;
    st_nxt[2].neg_frac = (q1 || q2) ? (!dneg && st_r[1].yy != st_r[1].xx) : dneg;
    st_nxt[2].clamp    = sq_sum >= cfg.top_sq;
    st_nxt[2].rem      = 25'd0;
    st_nxt[2].root     = 8'd0;

    // square root, two digits per stage, radicand bits 15:0 from the top down
    for (int k = 3; k <= 6; k++) begin
      sq_a = sqrt_step(st_r[k-1].rem[9:0], st_r[k-1].root,
                       st_r[k-1].r2[4*(6-k)+3 -: 2]);
      sq_b = sqrt_step(sq_a.rem, sq_a.root, st_r[k-1].r2[4*(6-k)+1 -: 2]);
      st_nxt[k].rem  = {15'd0, sq_b.rem};
      st_nxt[k].root = sq_b.root;
    end

    // clamp, dead zone, remap product
    speed   = st_r[6].clamp ? cfg.top : st_r[6].root;
    slope_w = {1'b0, cfg.top} - {1'b0, cfg.floor_spd};
    slope   = slope_w[8] ? (cfg.floor_spd - cfg.top) : slope_w[7:0];
    pm      = speed * slope;
    st_nxt[7].zero      = !(speed > cfg.dead && cfg.top != 8'd0);
    st_nxt[7].neg_slope = slope_w[8];
    st_nxt[7].rem       = {9'd0, pm};
    st_nxt[7].quo       = 8'd0;

    // divide by top_speed
    for (int k = 8; k <= 11; k++) begin
      dv_a = div_step(st_r[k-1].rem, st_r[k-1].quo, {17'd0, cfg.top} << (2*(11-k)+1));
      dv_b = div_step(dv_a.rem, dv_a.quo, {17'd0, cfg.top} << (2*(11-k)));
      st_nxt[k].rem = dv_b.rem;
      st_nxt[k].quo = dv_b.quo;
    end

    remap = st_r[11].neg_slope ? ({1'b0, cfg.floor_spd} - {1'b0, st_r[11].quo})
                               : ({1'b0, cfg.floor_spd} + {1'b0, st_r[11].quo});
    st_nxt[12].sp = st_r[11].zero ? 8'd0 : remap[7:0];

    fm = st_r[12].sp * st_r[12].dmag;
    st_nxt[13].rem = {1'b0, fm};
    st_nxt[13].quo = 8'd0;

    // divide by radius square
    for (int k = 14; k <= 17; k++) begin
      dv_a = div_step(st_r[k-1].rem, st_r[k-1].quo, {8'd0, st_r[k-1].r2} << (2*(17-k)+1));
      dv_b = div_step(dv_a.rem, dv_a.quo, {8'd0, st_r[k-1].r2} << (2*(17-k)));
      st_nxt[k].rem = dv_b.rem;
      st_nxt[k].quo = dv_b.quo;
    end

    // wheel commands: fl/br share factor A, fr/bl share factor B
    frac  = (st_r[17].sp == 8'd0) ? 8'd0 : st_r[17].quo;
    a_mag = st_r[17].unit_b ? frac : st_r[17].sp;
    a_neg = st_r[17].unit_b ? st_r[17].neg_frac : st_r[17].neg_unit;
    b_mag = st_r[17].unit_b ? st_r[17].sp : frac;
    b_neg = st_r[17].unit_b ? st_r[17].neg_unit : st_r[17].neg_frac;
    out_nxt.fl_rev  = a_neg && a_mag != 8'd0;
    out_nxt.fl_duty = duty_of(a_mag, cfg.floor_spd);
    out_nxt.br_rev  = a_neg && a_mag != 8'd0;
    out_nxt.br_duty = duty_of(a_mag, cfg.floor_spd);
    out_nxt.fr_rev  = b_neg && b_mag != 8'd0;
    out_nxt.fr_duty = duty_of(b_mag, cfg.floor_spd);
    out_nxt.bl_rev  = b_neg && b_mag != 8'd0;
    out_nxt.bl_duty = duty_of(b_mag, cfg.floor_spd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NumStages-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r  <= st_nxt;
      out_r <= out_nxt;
    end
  end

  // the remapped speed tops out at the larger of top and floor
  `MJDM_ASSERT_IMPL(a_duty_top, out_tvalid,
    (out_r.fl_duty <= cfg.top || out_r.fl_duty <= cfg.floor_spd) &&
    (out_r.fr_duty <= cfg.top || out_r.fr_duty <= cfg.floor_spd), "duty above speed range")
  `MJDM_ASSERT_IMPL(a_duty_floor, out_tvalid,
    (out_r.bl_duty == 8'd0 || out_r.bl_duty >= cfg.floor_spd), "duty below floor speed")
  `MJDM_ASSERT_IMPL(a_diag_pair, out_tvalid,
    out_r.fl_duty == out_r.br_duty && out_r.fr_rev == out_r.bl_rev, "diagonal pair differs")
  `MJDM_ASSERT_NEXT(a_hold, !en, out_tvalid && $stable(out_r), "stalled result changed")

endmodule

FILE: rtl/mjdm_cfg.sv
// Configuration register file of the drive mixer with its APB-style port.
// Depends on mjdm_pkg.
module mjdm_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output mjdm_pkg::cfg_t     cfg
);
  import mjdm_pkg::*;

  logic [7:0]  top_r;
  logic [7:0]  floor_r;
  logic [7:0]  dead_r;
  logic [16:0] top_sq_r;
  logic [8:0]  top_inc;
  logic [17:0] top_sq_nxt;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign top_inc    = {1'b0, top_r} + 9'd1;
  assign top_sq_nxt = top_inc * top_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r    <= TopReset;
      floor_r  <= FloorReset;
      dead_r   <= DeadReset;
      top_sq_r <= 17'd22801;
    end else begin
      top_sq_r <= top_sq_nxt[16:0];
      if (wr_en) begin
        case (cfg_paddr[3:2])
          RegTop:   top_r   <= cfg_pwdata[7:0];
          RegFloor: floor_r <= cfg_pwdata[7:0];
          RegDead:  dead_r  <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      RegTop:   cfg_prdata = {24'd0, top_r};
      RegFloor: cfg_prdata = {24'd0, floor_r};
      RegDead:  cfg_prdata = {24'd0, dead_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.top       = top_r;
  assign cfg.floor_spd = floor_r;
  assign cfg.dead      = dead_r;
  assign cfg.top_sq    = top_sq_r;

endmodule
